@@ rtl/pqve_pkg.sv @@
// Shared types and constants for the particle quad vertex expander.
// Used by every module of the block but pqve_checker; depends on nothing.
package pqve_pkg;

    localparam int SINE_LAT     = 22;
    localparam int MOTION_LAT   = 27;
    localparam int SINE_PAD     = MOTION_LAT - SINE_LAT;
    localparam int HORNER_STEPS = 8;
    localparam int SQRT_STAGES  = 16;
    localparam int DIV_STAGES   = 8;
    localparam int FIFO_DEPTH   = 4;
    localparam int FIFO_AW      = $clog2(FIFO_DEPTH);

    localparam logic [32:0] STEP_RAD     = 33'd6746518852;
    localparam logic [30:0] Q30_ONE      = 31'h4000_0000;
    localparam logic [14:0] QUARTER_TURN = 15'h4000;
    localparam logic [16:0] BLEND_MAX    = 17'h10000;
    localparam logic [1:0]  CORNER_LAST  = 2'd3;

    localparam logic [1:0] REG_MOTION_MODE  = 2'd0;
    localparam logic [1:0] REG_INV_BLEND    = 2'd1;
    localparam logic [1:0] REG_STRETCH_GAIN = 2'd2;

    localparam logic [1:0] CORNER_UV [4] = '{2'd0, 2'd1, 2'd3, 2'd2};

    typedef struct packed {
        logic [31:0] pos_x;
        logic [31:0] pos_y;
        logic [31:0] pos_z;
        logic [31:0] argb;
        logic [31:0] frame;
        logic [31:0] size_xp;
        logic [31:0] size_xn;
        logic [31:0] size_yp;
        logic [31:0] size_yn;
    } side_t;

    typedef struct packed {
        side_t       side;
        logic [14:0] sin_r;
        logic        sin_neg;
        logic [14:0] cos_r;
        logic        cos_neg;
        logic [31:0] mag_x;
        logic [31:0] mag_y;
        logic [31:0] mag_z;
        logic [2:0]  sgn;
        logic        motion;
    } req_t;

    typedef struct packed {
        logic [31:0] pos_x;
        logic [31:0] pos_y;
        logic [31:0] pos_z;
        logic [31:0] argb;
        logic [63:0] cos_sin;
        logic [31:0] frame;
        logic [63:0] size;
        logic [1:0]  uv;
        logic [47:0] dir;
        logic [31:0] stretch;
        logic [16:0] blend;
        logic        last;
    } vert_t;

endpackage

@@ rtl/pqve_front.sv @@
// Front end: classifies one particle into a request for the back end.
// Color packing, corner sizes, angle folding and velocity magnitudes; uses pqve_pkg.
module pqve_front
    import pqve_pkg::*;
(
    input  logic [31:0] pos_x,
    input  logic [31:0] pos_y,
    input  logic [31:0] pos_z,
    input  logic [63:0] color_rgba,
    input  logic [15:0] rotation_angle,
    input  logic [31:0] frame_word,
    input  logic [31:0] size_x,
    input  logic [31:0] size_y,
    input  logic [31:0] vel_x,
    input  logic [31:0] vel_y,
    input  logic [31:0] vel_z,
    input  logic        motion_mode,
    output req_t        req
);

    function automatic logic [7:0] chan(input logic [15:0] raw);
        logic [23:0] v;
        v = (24'(raw) * 24'd255) >> 12;
        if (raw[15])
            return 8'd0;
        else if (v > 24'd255)
            return 8'hFF;
        else
            return v[7:0];
    endfunction

    function automatic logic [31:0] neg_sat(input logic [31:0] v);
        if (v == 32'h8000_0000)
            return 32'h7FFF_FFFF;
        else
            return 32'd0 - v;
    endfunction

    function automatic logic [31:0] mag(input logic [31:0] v);
        return v[31] ? 32'd0 - v : v;
    endfunction

    logic [15:0] cos_ang;

    assign cos_ang = rotation_angle + 16'h4000;

    always_comb
    begin
        req.side.pos_x   = pos_x;
        req.side.pos_y   = pos_y;
        req.side.pos_z   = pos_z;
        req.side.argb    = {chan(color_rgba[15:0]), chan(color_rgba[63:48]),
                            chan(color_rgba[47:32]), chan(color_rgba[31:16])};
        req.side.frame   = frame_word;
        req.side.size_xp = size_x;
        req.side.size_xn = neg_sat(size_x);
        req.side.size_yp = size_y;
        req.side.size_yn = neg_sat(size_y);
        req.sin_r   = rotation_angle[14] ? QUARTER_TURN - 15'(rotation_angle[13:0])
                                         : 15'(rotation_angle[13:0]);
        req.sin_neg = rotation_angle[15];
        req.cos_r   = cos_ang[14] ? QUARTER_TURN - 15'(cos_ang[13:0]) : 15'(cos_ang[13:0]);
        req.cos_neg = cos_ang[15];
        req.mag_x   = mag(vel_x);
        req.mag_y   = mag(vel_y);
        req.mag_z   = mag(vel_z);
        req.sgn     = {vel_x[31], vel_y[31], vel_z[31]};
        req.motion  = motion_mode;
    end

endmodule

@@ rtl/pqve_fifo.sv @@
// Short request queue between front and back end.
// Holds classified particles; uses pqve_pkg for the request type.
module pqve_fifo
    import pqve_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic wr_en,
    input  req_t wr_data,
    output logic full,
    input  logic rd_en,
    output req_t rd_data,
    output logic empty
);

    req_t                 mem_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [FIFO_AW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [FIFO_AW:0]     count_reg, count_next;
    logic                 do_wr, do_rd;

    assign full    = (count_reg == (FIFO_AW+1)'(FIFO_DEPTH));
    assign empty   = (count_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_wr ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_rd ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + (FIFO_AW+1)'(do_wr) - (FIFO_AW+1)'(do_rd);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
            mem_reg[wr_ptr_reg] <= wr_data;
    end

endmodule

@@ rtl/pqve_sine.sv @@
// Pipelined quarter-wave sine: Horner series in Q30, two products per Horner term.
// Advances only while en is high; uses pqve_pkg.
module pqve_sine
    import pqve_pkg::*;
(
    input  logic        clk,
    input  logic        en,
    input  logic [14:0] r,
    input  logic        neg,
    output logic [31:0] sine
);

    logic [47:0] xprod_reg;
    logic        n1_reg, n2_reg, n3_reg, n4_reg, nf_reg;
    logic [30:0] x_s2_reg, x_s3_reg, x_s4_reg;
    logic [61:0] sq_reg;
    logic [31:0] x2_reg;

    logic [62:0] prod_reg [HORNER_STEPS];
    logic [64:0] pm_reg   [HORNER_STEPS];
    logic [31:0] x2_a_reg [HORNER_STEPS];
    logic [31:0] x2_b_reg [HORNER_STEPS];
    logic [30:0] x_a_reg  [HORNER_STEPS];
    logic [30:0] x_b_reg  [HORNER_STEPS];
    logic        n_a_reg  [HORNER_STEPS];
    logic        n_b_reg  [HORNER_STEPS];
    logic [31:0] x2_in    [HORNER_STEPS];
    logic [30:0] x_in     [HORNER_STEPS];
    logic        n_in     [HORNER_STEPS];
    logic [30:0] t_in     [HORNER_STEPS];
    logic [30:0] q_w      [HORNER_STEPS];

    logic [61:0] fprod_reg;
    logic [30:0] t_fin;
    logic [31:0] s_rnd, s_sat;
    logic [31:0] sine_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            xprod_reg <= 48'(r) * 48'(STEP_RAD);
            n1_reg    <= neg;
            x_s2_reg  <= 31'((xprod_reg + 48'd32768) >> 16);
            n2_reg    <= n1_reg;
            sq_reg    <= 62'(x_s2_reg) * 62'(x_s2_reg);
            x_s3_reg  <= x_s2_reg;
            n3_reg    <= n2_reg;
            x2_reg    <= 32'((sq_reg + 62'h2000_0000) >> 30);
            x_s4_reg  <= x_s3_reg;
            n4_reg    <= n3_reg;
        end
    end

    for (genvar i = 0; i < HORNER_STEPS; i++)
    begin : g_step
        localparam int K = HORNER_STEPS - i;
        localparam int D = 2 * K * (2 * K + 1);
        localparam int L = $clog2(D);
        localparam logic [32:0] M = 33'(((65'd1 << (32 + L)) + 65'(D) - 65'd1) / 65'(D));

        if (i == 0)
        begin : g_first
            assign x2_in[i] = x2_reg;
            assign x_in[i]  = x_s4_reg;
            assign n_in[i]  = n4_reg;
            assign t_in[i]  = Q30_ONE;
        end
        else
        begin : g_next
            assign x2_in[i] = x2_b_reg[i-1];
            assign x_in[i]  = x_b_reg[i-1];
            assign n_in[i]  = n_b_reg[i-1];
            assign t_in[i]  = Q30_ONE - q_w[i-1];
        end

        assign q_w[i] = 31'(pm_reg[i] >> (32 + L));

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                prod_reg[i] <= 63'(x2_in[i]) * 63'(t_in[i]);
                x2_a_reg[i] <= x2_in[i];
                x_a_reg[i]  <= x_in[i];
                n_a_reg[i]  <= n_in[i];
                pm_reg[i]   <= 65'(32'((prod_reg[i] + 63'h2000_0000) >> 30)) * 65'(M);
                x2_b_reg[i] <= x2_a_reg[i];
                x_b_reg[i]  <= x_a_reg[i];
                n_b_reg[i]  <= n_a_reg[i];
            end
        end
    end

    assign t_fin = Q30_ONE - q_w[HORNER_STEPS-1];
    assign s_rnd = 32'((fprod_reg + 62'h2000_0000) >> 30);
    assign s_sat = (s_rnd > 32'(Q30_ONE)) ? 32'(Q30_ONE) : s_rnd;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            fprod_reg <= 62'(x_b_reg[HORNER_STEPS-1]) * 62'(t_fin);
            nf_reg    <= n_b_reg[HORNER_STEPS-1];
            sine_reg  <= nf_reg ? 32'd0 - s_sat : s_sat;
        end
    end

    assign sine = sine_reg;

endmodule

@@ rtl/pqve_motion.sv @@
// Pipelined motion terms: velocity length by bit-pair square root, then
// direction by restoring division, stretch and blend products. Uses pqve_pkg.
module pqve_motion
    import pqve_pkg::*;
(
    input  logic        clk,
    input  logic        en,
    input  logic [31:0] mag_x,
    input  logic [31:0] mag_y,
    input  logic [31:0] mag_z,
    input  logic [2:0]  sgn,
    input  logic        motion,
    input  logic [31:0] stretch_gain,
    input  logic [31:0] inverse_blend_range,
    output logic [47:0] dir,
    output logic [31:0] stretch,
    output logic [16:0] blend
);

    logic [63:0] sqx_reg, sqy_reg, sqz_reg, sum_reg;
    logic [31:0] m1_reg [3];
    logic [31:0] m2_reg [3];
    logic [2:0]  s1_reg, s2_reg;
    logic        mo1_reg, mo2_reg;

    logic [63:0] v_reg   [SQRT_STAGES];
    logic [63:0] res_reg [SQRT_STAGES];
    logic [31:0] mq_reg  [SQRT_STAGES][3];
    logic [2:0]  sq_sgn_reg [SQRT_STAGES];
    logic        sq_mo_reg  [SQRT_STAGES];

    logic [45:0] rem_reg  [DIV_STAGES][3];
    logic [14:0] quo_reg  [DIV_STAGES][3];
    logic [31:0] len_reg  [DIV_STAGES];
    logic [2:0]  dv_sgn_reg [DIV_STAGES];
    logic        dv_mo_reg  [DIV_STAGES];
    logic [63:0] sprod_reg [DIV_STAGES];
    logic [63:0] bprod_reg [DIV_STAGES];

    logic [47:0] dir_reg, dir_next;
    logic [31:0] stretch_reg, stretch_next;
    logic [16:0] blend_reg, blend_next;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sqx_reg <= 64'(mag_x) * 64'(mag_x);
            sqy_reg <= 64'(mag_y) * 64'(mag_y);
            sqz_reg <= 64'(mag_z) * 64'(mag_z);
            m1_reg[0] <= mag_x;
            m1_reg[1] <= mag_y;
            m1_reg[2] <= mag_z;
            s1_reg  <= sgn;
            mo1_reg <= motion;
            sum_reg <= sqx_reg + sqy_reg + sqz_reg;
            m2_reg  <= m1_reg;
            s2_reg  <= s1_reg;
            mo2_reg <= mo1_reg;
        end
    end

    for (genvar j = 0; j < SQRT_STAGES; j++)
    begin : g_sqrt
        logic [63:0] v_in, res_in, v_out, res_out;
        logic [31:0] m_in [3];
        logic [2:0]  s_in;
        logic        mo_in;

        if (j == 0)
        begin : g_first
            assign v_in   = sum_reg;
            assign res_in = '0;
            assign m_in   = m2_reg;
            assign s_in   = s2_reg;
            assign mo_in  = mo2_reg;
        end
        else
        begin : g_next
            assign v_in   = v_reg[j-1];
            assign res_in = res_reg[j-1];
            assign m_in   = mq_reg[j-1];
            assign s_in   = sq_sgn_reg[j-1];
            assign mo_in  = sq_mo_reg[j-1];
        end

        always_comb
        begin
            logic [63:0] v, rs, b;
            v  = v_in;
            rs = res_in;
            for (int n = 0; n < 2; n++)
            begin
                b = 64'd1 << (62 - 2 * (2 * j + n));
                if (v >= rs + b)
                begin
                    v  = v - (rs + b);
                    rs = (rs >> 1) + b;
                end
                else
                    rs = rs >> 1;
            end
            v_out   = v;
            res_out = rs;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                v_reg[j]      <= v_out;
                res_reg[j]    <= res_out;
                mq_reg[j]     <= m_in;
                sq_sgn_reg[j] <= s_in;
                sq_mo_reg[j]  <= mo_in;
            end
        end
    end

    for (genvar j = 0; j < DIV_STAGES; j++)
    begin : g_div
        logic [45:0] r_in  [3];
        logic [14:0] q_in  [3];
        logic [45:0] r_out [3];
        logic [14:0] q_out [3];
        logic [31:0] len_in;
        logic [2:0]  s_in;
        logic        mo_in;
        logic [63:0] sp_in, bp_in;

        if (j == 0)
        begin : g_first
            assign len_in = res_reg[SQRT_STAGES-1][31:0];
            for (genvar l = 0; l < 3; l++)
            begin : g_lane
                assign r_in[l] = {14'd0, mq_reg[SQRT_STAGES-1][l]} << 14;
                assign q_in[l] = '0;
            end
            assign s_in  = sq_sgn_reg[SQRT_STAGES-1];
            assign mo_in = sq_mo_reg[SQRT_STAGES-1];
            assign sp_in = 64'(stretch_gain) * 64'(len_in);
            assign bp_in = 64'(inverse_blend_range) * 64'(len_in);
        end
        else
        begin : g_next
            assign len_in = len_reg[j-1];
            assign r_in   = rem_reg[j-1];
            assign q_in   = quo_reg[j-1];
            assign s_in   = dv_sgn_reg[j-1];
            assign mo_in  = dv_mo_reg[j-1];
            assign sp_in  = sprod_reg[j-1];
            assign bp_in  = bprod_reg[j-1];
        end

        always_comb
        begin
            logic [45:0] r;
            logic [14:0] q;
            int          bp;
            for (int l = 0; l < 3; l++)
            begin
                r = r_in[l];
                q = q_in[l];
                for (int n = 0; n < 2; n++)
                begin
                    bp = 14 - 2 * j - n;
                    if (bp >= 0)
                    begin
                        if ({1'b0, r} >= (47'(len_in) << bp))
                        begin
                            r = 46'({1'b0, r} - (47'(len_in) << bp));
                            q = q | (15'd1 << bp);
                        end
                    end
                end
                r_out[l] = r;
                q_out[l] = q;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[j]    <= r_out;
                quo_reg[j]    <= q_out;
                len_reg[j]    <= len_in;
                dv_sgn_reg[j] <= s_in;
                dv_mo_reg[j]  <= mo_in;
                sprod_reg[j]  <= sp_in;
                bprod_reg[j]  <= bp_in;
            end
        end
    end

    always_comb
    begin
        logic [47:0] sh, bh;
        logic [15:0] part [3];
        logic        live;
        live = dv_mo_reg[DIV_STAGES-1] && (len_reg[DIV_STAGES-1] != '0);
        for (int l = 0; l < 3; l++)
            part[l] = dv_sgn_reg[DIV_STAGES-1][2-l]
                      ? 16'd0 - {1'b0, quo_reg[DIV_STAGES-1][l]}
                      : {1'b0, quo_reg[DIV_STAGES-1][l]};
        sh = 48'(sprod_reg[DIV_STAGES-1] >> 16);
        bh = 48'(bprod_reg[DIV_STAGES-1] >> 16);
        dir_next     = live ? {part[0], part[1], part[2]} : '0;
        stretch_next = !dv_mo_reg[DIV_STAGES-1] ? '0 : (|sh[47:32]) ? '1 : sh[31:0];
        blend_next   = !dv_mo_reg[DIV_STAGES-1] ? '0
                     : (bh > 48'(BLEND_MAX)) ? BLEND_MAX : bh[16:0];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dir_reg     <= dir_next;
            stretch_reg <= stretch_next;
            blend_reg   <= blend_next;
        end
    end

    assign dir     = dir_reg;
    assign stretch = stretch_reg;
    assign blend   = blend_reg;

endmodule

@@ rtl/pqve_back.sv @@
// Back end: runs requests through the sine and motion pipelines, then
// expands each particle into four corner vertices. Uses pqve_pkg, pqve_sine, pqve_motion.
module pqve_back
    import pqve_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  req_t        req,
    input  logic        req_empty,
    output logic        req_pop,
    input  logic [31:0] stretch_gain,
    input  logic [31:0] inverse_blend_range,
    input  logic        pop,
    output logic        empty,
    output vert_t       vert
);

    logic [MOTION_LAT-1:0] vld_reg;
    side_t                 side_reg [MOTION_LAT];
    logic [31:0]           sin_pad_reg [SINE_PAD];
    logic [31:0]           cos_pad_reg [SINE_PAD];
    logic [31:0]           sin_w, cos_w;
    logic [47:0]           dir_w;
    logic [31:0]           stretch_w;
    logic [16:0]           blend_w;

    logic                  hold_valid_reg, hold_valid_next;
    logic [1:0]            corner_reg, corner_next;
    side_t                 hold_reg;
    logic [63:0]           hcs_reg;
    logic [47:0]           hdir_reg;
    logic [31:0]           hstretch_reg;
    logic [16:0]           hblend_reg;

    logic                  take, en, out_last;

    assign out_last = vld_reg[MOTION_LAT-1];
    assign take     = !hold_valid_reg || (pop && corner_reg == CORNER_LAST);
    assign en       = !out_last || take;
    assign req_pop  = en && !req_empty;

    pqve_sine u_sin (
        .clk  (clk),
        .en   (en),
        .r    (req.sin_r),
        .neg  (req.sin_neg),
        .sine (sin_w)
    );

    pqve_sine u_cos (
        .clk  (clk),
        .en   (en),
        .r    (req.cos_r),
        .neg  (req.cos_neg),
        .sine (cos_w)
    );

    pqve_motion u_motion (
        .clk                 (clk),
        .en                  (en),
        .mag_x               (req.mag_x),
        .mag_y               (req.mag_y),
        .mag_z               (req.mag_z),
        .sgn                 (req.sgn),
        .motion              (req.motion),
        .stretch_gain        (stretch_gain),
        .inverse_blend_range (inverse_blend_range),
        .dir                 (dir_w),
        .stretch             (stretch_w),
        .blend               (blend_w)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[MOTION_LAT-2:0], req_pop};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_reg[0]    <= req.side;
            sin_pad_reg[0] <= sin_w;
            cos_pad_reg[0] <= cos_w;
            for (int i = 1; i < MOTION_LAT; i++)
                side_reg[i] <= side_reg[i-1];
            for (int i = 1; i < SINE_PAD; i++)
            begin
                sin_pad_reg[i] <= sin_pad_reg[i-1];
                cos_pad_reg[i] <= cos_pad_reg[i-1];
            end
        end
    end

    always_comb
    begin
        hold_valid_next = hold_valid_reg;
        corner_next     = corner_reg;
        if (take)
        begin
            hold_valid_next = out_last;
            corner_next     = '0;
        end
        else if (pop)
            corner_next = corner_reg + 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
            corner_reg     <= '0;
        end
        else
        begin
            hold_valid_reg <= hold_valid_next;
            corner_reg     <= corner_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && out_last)
        begin
            hold_reg     <= side_reg[MOTION_LAT-1];
            hcs_reg      <= {cos_pad_reg[SINE_PAD-1], sin_pad_reg[SINE_PAD-1]};
            hdir_reg     <= dir_w;
            hstretch_reg <= stretch_w;
            hblend_reg   <= blend_w;
        end
    end

    always_comb
    begin
        vert.pos_x   = hold_reg.pos_x;
        vert.pos_y   = hold_reg.pos_y;
        vert.pos_z   = hold_reg.pos_z;
        vert.argb    = hold_reg.argb;
        vert.cos_sin = hcs_reg;
        vert.frame   = hold_reg.frame;
        vert.size    = {(corner_reg == 2'd1 || corner_reg == 2'd2) ? hold_reg.size_xp
                                                                   : hold_reg.size_xn,
                        corner_reg[1] ? hold_reg.size_yp : hold_reg.size_yn};
        vert.uv      = CORNER_UV[corner_reg];
        vert.dir     = hdir_reg;
        vert.stretch = hstretch_reg;
        vert.blend   = hblend_reg;
        vert.last    = (corner_reg == CORNER_LAST);
    end

    assign empty = !hold_valid_reg;

endmodule

@@ rtl/particle_quad_vertex_expander.sv @@
// Particle quad vertex expander top level: register port, front, queue, back.
// Uses pqve_pkg, pqve_front, pqve_fifo and pqve_back.
//
// Usage: push one particle when full is low; four corner vertices (0..3,
// last_corner on the fourth) appear in order on the result ports while
// empty is low, each taken by pop. Registers sit on the APB port at
// 0x0 motion_mode, 0x4 inverse_blend_range, 0x8 stretch_gain; write them
// only while no particle is in flight.
// A particle reaches the ports through the queue, the 27-stage motion
// pipeline (squares and sum, 16 square-root stages, 8 division stages,
// output register) and then the output hold. Each particle takes four
// pops at the single vertex output; the pipelines themselves take one
// request per cycle while they are not frozen.
// Reset clears the queue, the pipeline valid bits, the output hold and the
// three configuration registers. When pop stays low the output hold keeps
// its vertex, the pipeline freezes once its last stage holds a particle,
// the 4-deep queue fills, and full rises.
module particle_quad_vertex_expander
    import pqve_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               push,
    output logic               full,
    input  logic signed [31:0] pos_x,
    input  logic signed [31:0] pos_y,
    input  logic signed [31:0] pos_z,
    input  logic [63:0]        color_rgba,
    input  logic [15:0]        rotation_angle,
    input  logic [31:0]        frame_word,
    input  logic signed [31:0] size_x,
    input  logic signed [31:0] size_y,
    input  logic signed [31:0] vel_x,
    input  logic signed [31:0] vel_y,
    input  logic signed [31:0] vel_z,
    output logic               empty,
    input  logic               pop,
    output logic signed [31:0] out_pos_x,
    output logic signed [31:0] out_pos_y,
    output logic signed [31:0] out_pos_z,
    output logic [31:0]        packed_argb,
    output logic [63:0]        cos_sin,
    output logic [31:0]        out_frame,
    output logic [63:0]        corner_size,
    output logic [1:0]         corner_uv,
    output logic [47:0]        unit_direction,
    output logic [31:0]        stretch_amount,
    output logic [16:0]        blend_amount,
    output logic               last_corner
);

    logic        motion_mode_reg;
    logic [31:0] inv_blend_reg;
    logic [31:0] stretch_gain_reg;
    logic        cfg_wr;

    req_t        front_req, fifo_req;
    logic        fifo_empty, fifo_pop;
    vert_t       vert;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            motion_mode_reg  <= 1'b0;
            inv_blend_reg    <= '0;
            stretch_gain_reg <= '0;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[3:2])
                REG_MOTION_MODE:  motion_mode_reg  <= pwdata[0];
                REG_INV_BLEND:    inv_blend_reg    <= pwdata;
                REG_STRETCH_GAIN: stretch_gain_reg <= pwdata;
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            REG_MOTION_MODE:  prdata = {31'd0, motion_mode_reg};
            REG_INV_BLEND:    prdata = inv_blend_reg;
            REG_STRETCH_GAIN: prdata = stretch_gain_reg;
            default:          prdata = '0;
        endcase
    end

    pqve_front u_front (
        .pos_x          (pos_x),
        .pos_y          (pos_y),
        .pos_z          (pos_z),
        .color_rgba     (color_rgba),
        .rotation_angle (rotation_angle),
        .frame_word     (frame_word),
        .size_x         (size_x),
        .size_y         (size_y),
        .vel_x          (vel_x),
        .vel_y          (vel_y),
        .vel_z          (vel_z),
        .motion_mode    (motion_mode_reg),
        .req            (front_req)
    );

    pqve_fifo u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (push),
        .wr_data (front_req),
        .full    (full),
        .rd_en   (fifo_pop),
        .rd_data (fifo_req),
        .empty   (fifo_empty)
    );

    pqve_back u_back (
        .clk                 (clk),
        .rst_n               (rst_n),
        .req                 (fifo_req),
        .req_empty           (fifo_empty),
        .req_pop             (fifo_pop),
        .stretch_gain        (stretch_gain_reg),
        .inverse_blend_range (inv_blend_reg),
        .pop                 (pop),
        .empty               (empty),
        .vert                (vert)
    );

    assign out_pos_x      = vert.pos_x;
    assign out_pos_y      = vert.pos_y;
    assign out_pos_z      = vert.pos_z;
    assign packed_argb    = vert.argb;
    assign cos_sin        = vert.cos_sin;
    assign out_frame      = vert.frame;
    assign corner_size    = vert.size;
    assign corner_uv      = vert.uv;
    assign unit_direction = vert.dir;
    assign stretch_amount = vert.stretch;
    assign blend_amount   = vert.blend;
    assign last_corner    = vert.last;

endmodule

@@ rtl/pqve_checker.sv @@
// Port-level checks on the vertex stream of the quad expander.
// Bound to particle_quad_vertex_expander; no package needed.
module pqve_checker
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               empty,
    input  logic               pop,
    input  logic signed [31:0] out_pos_x,
    input  logic [31:0]        out_frame,
    input  logic [1:0]         corner_uv,
    input  logic [16:0]        blend_amount,
    input  logic               last_corner
);

    a_quad_held: assert property (@(posedge clk) disable iff (!rst_n)
        pop && !empty && !last_corner |=> !empty && $stable(out_frame) && $stable(out_pos_x))
        else $error("quad dropped before its last corner");

    a_corner_order: assert property (@(posedge clk) disable iff (!rst_n)
        pop && !empty && !last_corner |=>
            ($past(corner_uv) == 2'd0 && corner_uv == 2'd1) ||
            ($past(corner_uv) == 2'd1 && corner_uv == 2'd3) ||
            ($past(corner_uv) == 2'd3 && corner_uv == 2'd2))
        else $error("corner order broken");

    a_last_mark: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> last_corner == (corner_uv == 2'd2))
        else $error("last corner mark wrong");

    a_blend_range: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> blend_amount <= 17'h10000)
        else $error("blend above one");

endmodule

bind particle_quad_vertex_expander pqve_checker u_pqve_checker (.*);
